// ===== rtl/bfha_pkg.sv =====
// ----------------------------------------------------------------------------
// bfha_pkg
// Types and constants shared by the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD     = 2'd1;
  localparam logic [1:0] STAT_NOFIT   = 2'd2;
  localparam logic [1:0] STAT_DBLFREE = 2'd3;

  localparam int BYTES_W  = 13;
  localparam int HEAP_MAX = 4096;
  localparam int HEAP_MIN = 16;

  typedef struct packed {
    logic        action;
    logic [12:0] request_bytes;
    logic [11:0] payload_offset;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_offset;
  } rsp_word_t;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_INIT2, S_IDLE,
    S_A_RQ, S_A_CHK, S_A_WRH, S_A_RDN, S_A_ORN, S_A_WRN, S_A_WRF,
    S_F_RQ, S_F_CHK, S_F_RDN, S_F_NXT, S_F_RDP, S_F_PRV, S_F_RDS,
    S_F_WRH, S_F_WRF, S_F_RDX, S_F_CLX, S_DONE
  } state_t;

endpackage

// ===== rtl/bfha_ram.sv =====
// ----------------------------------------------------------------------------
// bfha_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/best_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_unit
// Best-fit allocator over an implicit block list kept in one word RAM.
// ----------------------------------------------------------------------------
// One word at a time. After reset or a cfg_we write the heap is laid out
// as one free block header, its footer and an end marker. An allocate walks
// every block header (one RAM read port), then writes the best block's header
// and either splits off the rest or marks the next header. A free walks headers
// up to the freed block, then coalesces it with free neighbors. Each word is held in an
// output register, so a new word may be taken while a result waits.
module best_fit_heap_allocator_unit
  import bfha_pkg::*;
#(
  parameter int HEAP_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_word_t   req_word,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_word_t   rsp_word,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);

  localparam int AW     = $clog2(HEAP_WORDS);
  localparam int CAP    = (HEAP_WORDS * 4) & ~7;
  localparam int HB_TOP = (CAP < HEAP_MAX) ? CAP : HEAP_MAX;
  localparam int CW     = ((AW > 11) ? AW : 11) + 1;

  state_t state, state_next;

  logic [12:0]   hb, hb_next;
  logic [AW-1:0] w, h, best, start, nx;
  logic [12:0]   best_sz, total;
  logic [13:0]   need;
  logic          found, best_prev, hv_prev;
  logic [1:0]    res_stat;
  logic [11:0]   res_grant;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, q;
  logic [12:0]   q_sz, hs, rem;
  logic          accept, rsp_free;

  assign q_sz     = {q[12:2], 2'b00};
  assign hs       = hb - 13'd8;
  assign rem      = best_sz - need[12:0];
  assign accept   = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || cfg_we;

  bfha_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(q)
  );

  always_comb begin
    hb_next = {cfg_wdata[12:3], 3'b000};
    if (hb_next < 13'(HEAP_MIN)) hb_next = 13'(HEAP_MIN);
    if (hb_next > 13'(HB_TOP)) hb_next = 13'(HB_TOP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = w;
    mem_wdata  = 32'd0;
    unique case (state)
      S_INIT0: begin
        mem_we = 1'b1; mem_addr = AW'(1); mem_wdata = 32'({hs[12:2], 2'b10});
        state_next = S_INIT1;
      end
      S_INIT1: begin
        mem_we = 1'b1; mem_addr = AW'(hs[12:2]); mem_wdata = 32'(hs);
        state_next = S_INIT2;
      end
      S_INIT2: begin
        mem_we = 1'b1; mem_addr = AW'(hs[12:2]) + AW'(1); mem_wdata = 32'd1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (req_word.action == ACT_ALLOC) begin
            state_next = (req_word.request_bytes == 13'd0) ? S_DONE : S_A_RQ;
          end else if (req_word.payload_offset[2:0] != 3'd0 ||
                       req_word.payload_offset < 12'd8 ||
                       13'(req_word.payload_offset) >= hb) begin
            state_next = S_DONE;
          end else begin
            state_next = S_F_RQ;
          end
        end
      end
      S_A_RQ: state_next = S_A_CHK;
      S_A_CHK: begin
        if (q_sz == 13'd0) begin
          state_next = (found || (q[0] == 1'b0 && 14'(q_sz) >= need)) ? S_A_WRH : S_DONE;
        end else begin
          state_next = S_A_RQ;
        end
      end
      S_A_WRH: begin
        mem_we = 1'b1; mem_addr = best;
        mem_wdata = 32'({need[12:2], best_prev, 1'b1});
        state_next = (rem == 13'd0) ? S_A_RDN : S_A_WRN;
      end
      S_A_RDN: begin mem_addr = nx; state_next = S_A_ORN; end
      S_A_ORN: begin
        mem_we = 1'b1; mem_addr = nx; mem_wdata = q | 32'd2; state_next = S_DONE;
      end
      S_A_WRN: begin
        mem_we = 1'b1; mem_addr = nx; mem_wdata = 32'({rem[12:2], 2'b10});
        state_next = S_A_WRF;
      end
      S_A_WRF: begin
        mem_we = 1'b1; mem_addr = nx + AW'(rem[12:2]) - AW'(1); mem_wdata = 32'(rem);
        state_next = S_DONE;
      end
      S_F_RQ: state_next = (CW'(w) > CW'(h)) ? S_DONE : S_F_CHK;
      S_F_CHK: begin
        if (q_sz == 13'd0) state_next = S_DONE;
        else if (w == h) state_next = (q[0] == 1'b0) ? S_DONE : S_F_RDN;
        else state_next = S_F_RQ;
      end
      S_F_RDN: begin mem_addr = nx; state_next = S_F_NXT; end
      S_F_NXT: state_next = hv_prev ? S_F_RDS : S_F_RDP;
      S_F_RDP: begin mem_addr = h - AW'(1); state_next = S_F_PRV; end
      S_F_PRV: state_next = S_F_RDS;
      S_F_RDS: begin mem_addr = start; state_next = S_F_WRH; end
      S_F_WRH: begin
        mem_we = 1'b1; mem_addr = start;
        mem_wdata = 32'({total[12:2], q[1], 1'b0});
        state_next = S_F_WRF;
      end
      S_F_WRF: begin
        mem_we = 1'b1; mem_addr = start + AW'(total[12:2]) - AW'(1);
        mem_wdata = 32'(total);
        state_next = S_F_RDX;
      end
      S_F_RDX: begin mem_addr = start + AW'(total[12:2]); state_next = S_F_CLX; end
      S_F_CLX: begin
        mem_we = 1'b1; mem_addr = start + AW'(total[12:2]);
        mem_wdata = q & ~32'd2; state_next = S_DONE;
      end
      S_DONE: if (rsp_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (cfg_we) state_next = S_INIT0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hb <= 13'(HB_TOP);
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) hb <= hb_next;
      if (state == S_DONE && rsp_free) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp_word.status         <= res_stat;
      rsp_word.granted_offset <= res_grant;
    end
    case (state)
      S_IDLE: begin
        w         <= AW'(1);
        h         <= AW'(req_word.payload_offset[11:2]) - AW'(1);
        need      <= (14'(req_word.request_bytes) + 14'd11) & ~14'd7;
        found     <= 1'b0;
        res_grant <= 12'd0;
        res_stat  <= STAT_BAD;
      end
      S_A_CHK: begin
        if (q_sz == 13'd0) begin
          res_stat <= STAT_NOFIT;
        end else begin
          if (q[0] == 1'b0 && 14'(q_sz) >= need && (!found || q_sz < best_sz)) begin
            found     <= 1'b1;
            best      <= w;
            best_sz   <= q_sz;
            best_prev <= q[1];
          end
          w <= w + AW'(q_sz[12:2]);
        end
      end
      S_A_WRH: begin
        nx        <= best + AW'(need[12:2]);
        res_stat  <= STAT_OK;
        res_grant <= 12'({best + AW'(1), 2'b00});
      end
      S_F_CHK: begin
        if (q_sz != 13'd0 && w == h) begin
          hv_prev <= q[1];
          total   <= q_sz;
          start   <= h;
          nx      <= h + AW'(q_sz[12:2]);
          if (q[0] == 1'b0) res_stat <= STAT_DBLFREE;
        end
        w <= w + AW'(q_sz[12:2]);
      end
      S_F_NXT: begin
        if (q_sz != 13'd0 && q[0] == 1'b0) total <= total + q_sz;
      end
      S_F_PRV: begin
        if (q_sz != 13'd0 && CW'(q_sz[12:2]) <= CW'(h) - CW'(1)) begin
          start <= h - AW'(q_sz[12:2]);
          total <= total + q_sz;
        end
      end
      S_F_CLX: res_stat <= STAT_OK;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_grant_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_word.granted_offset[2:0] == 3'd0)
    else $error("granted offset misaligned");
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.status != STAT_OK |-> rsp_word.granted_offset == 12'd0)
    else $error("grant on failed request");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_we)
    else $error("heap write while idle");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted word not processed");
`endif

endmodule

// ===== verif/best_fit_heap_allocator_unit_test.sv =====
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_unit_test
// Self-checking bench for the best-fit heap allocator.
// ----------------------------------------------------------------------------
// A shadow heap in the bench replays every accepted request word and predicts
// the status and granted offset. Directed cases cover bad sizes and pointers,
// exact fits, splits, double frees and coalescing; heap size writes cover the
// extremes; random traffic mixes allocates, frees of live blocks and junk.
// Both handshakes idle and stall at random, with one long receiver hold.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_unit_test;
  import bfha_pkg::*;

  localparam int WORDS = 1024;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_word_t   req_word;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_word_t   rsp_word;
  logic        cfg_we;
  logic [12:0] cfg_wdata;

  best_fit_heap_allocator_unit #(.HEAP_WORDS(WORDS)) u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow heap
  logic [31:0] shadow_heap [WORDS];
  int unsigned heap_size;

  rsp_word_t   pending_rsp [$];
  int unsigned live_blocks [$];
  int          fail_count = 0;
  int          burst_left = 0;
  bit          send_idle = 1'b1;
  bit          rx_stall_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  function automatic logic [31:0] hrd(int unsigned i);
    return (i < WORDS) ? shadow_heap[i] : 32'd0;
  endfunction

  function automatic void hwr(int unsigned i, logic [31:0] v);
    if (i < WORDS) shadow_heap[i] = v;
  endfunction

  function automatic void heap_layout();
    int unsigned s;
    s = heap_size - 8;
    for (int i = 0; i < WORDS; i++) shadow_heap[i] = '0;
    hwr(1, s | 2);
    hwr(s / 4, s);
    hwr((s + 4) / 4, 1);
  endfunction

  function automatic void heap_resize(logic [12:0] v);
    int unsigned hb;
    hb = v & ~13'd7;
    if (hb < HEAP_MIN) hb = HEAP_MIN;
    if (hb > HEAP_MAX) hb = HEAP_MAX;
    if (hb > WORDS * 4) hb = WORDS * 4;
    heap_size = hb;
    heap_layout();
  endfunction

  function automatic rsp_word_t heap_alloc(int unsigned req);
    rsp_word_t r;
    int unsigned need, w, best, best_sz, v, sz, rem, nx;
    bit found;
    r = '0;
    w = 1; best = 0; best_sz = 0; found = 0;
    if (req == 0) begin
      r.status = STAT_BAD;
      return r;
    end
    need = (req + 11) & ~32'd7;
    for (int n = 0; n < WORDS && w < WORDS; n++) begin
      v = hrd(w);
      sz = v & ~32'd3;
      if (sz == 0) break;
      if (!v[0] && sz >= need && (!found || sz < best_sz)) begin
        found = 1; best = w; best_sz = sz;
      end
      w += sz / 4;
    end
    if (!found) begin
      r.status = STAT_NOFIT;
      return r;
    end
    v = hrd(best);
    rem = best_sz - need;
    nx = best + need / 4;
    hwr(best, need | (v & 2) | 1);
    if (rem == 0) begin
      hwr(nx, hrd(nx) | 2);
    end else begin
      hwr(nx, rem | 2);
      hwr(nx + rem / 4 - 1, rem);
    end
    r.status = STAT_OK;
    r.granted_offset = 12'((best + 1) * 4);
    return r;
  endfunction

  function automatic rsp_word_t heap_free(int unsigned off);
    rsp_word_t r;
    int unsigned h, w, v, s, sz, start, total, nx, nv, ps;
    bit hit;
    r = '0;
    w = 1; hit = 0;
    r.status = STAT_BAD;
    if ((off & 7) != 0 || off < 8) return r;
    h = off / 4 - 1;
    if (h * 4 + 4 >= heap_size) return r;
    for (int n = 0; n < WORDS && w < WORDS && w <= h; n++) begin
      s = hrd(w) & ~32'd3;
      if (s == 0) break;
      if (w == h) begin
        hit = 1;
        break;
      end
      w += s / 4;
    end
    if (!hit) return r;
    v = hrd(h);
    if (!v[0]) begin
      r.status = STAT_DBLFREE;
      return r;
    end
    sz = v & ~32'd3;
    start = h;
    total = sz;
    nx = h + sz / 4;
    nv = hrd(nx);
    if ((nv & ~32'd3) != 0 && !nv[0]) total += nv & ~32'd3;
    if (!v[1]) begin
      ps = hrd(h - 1) & ~32'd3;
      if (ps != 0 && ps / 4 <= h - 1) begin
        start = h - ps / 4;
        total += ps;
      end
    end
    hwr(start, total | (hrd(start) & 2));
    hwr(start + total / 4 - 1, total);
    nx = start + total / 4;
    hwr(nx, hrd(nx) & ~32'd2);
    r.status = STAT_OK;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // response checker
  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected word", rsp_word, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_word.status !== want.status)
          report("status", rsp_word.status, want.status);
        if (rsp_word.granted_offset !== want.granted_offset)
          report("granted_offset", rsp_word.granted_offset, want.granted_offset);
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (rx_stall_on) begin
      rsp_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  task automatic send_word(logic act, int unsigned bytes, int unsigned off);
    req_word_t w;
    rsp_word_t r;
    w.action = act;
    w.request_bytes = 13'(bytes);
    w.payload_offset = 12'(off);
    if (send_idle && burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    req_valid <= 1'b1;
    req_word <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (act == ACT_ALLOC) begin
      r = heap_alloc(w.request_bytes);
      if (r.status == STAT_OK) live_blocks.push_back(r.granted_offset);
    end else begin
      r = heap_free(w.payload_offset);
      foreach (live_blocks[i])
        if (r.status == STAT_OK && live_blocks[i] == w.payload_offset) begin
          live_blocks.delete(i);
          break;
        end
    end
    pending_rsp.push_back(r);
  endtask

  task automatic wait_drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_heap_size(logic [12:0] v);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_resize(v);
    live_blocks.delete();
  endtask

  task automatic alloc_req(int unsigned bytes);
    send_word(ACT_ALLOC, bytes, $urandom_range(0, 4095));
  endtask

  task automatic free_req(int unsigned off);
    send_word(ACT_FREE, $urandom_range(0, 8191), off);
  endtask

  task automatic test_directed();
    alloc_req(0);
    alloc_req(4096);
    alloc_req(8191);
    free_req(4095);
    free_req(0);
    free_req(4088);
    alloc_req(1);          // 8-byte block at 8
    alloc_req(12);         // 16-byte block at 16
    alloc_req(20);         // 24-byte block at 32
    alloc_req(4);
    free_req(12);          // inside a block, not a header
    free_req(16);
    free_req(16);          // double free
    free_req(32);          // joins free neighbor below
    free_req(56);          // joins free neighbors on both sides
    free_req(8);           // joins free neighbor above
    alloc_req(4088 - 4);   // whole heap, exact fit
    alloc_req(1);
    free_req(8);
    alloc_req(100);
    alloc_req(2000);
    free_req(8);
  endtask

  task automatic test_heap_sizes();
    write_heap_size(13'd16);
    alloc_req(4);
    alloc_req(1);
    free_req(8);
    alloc_req(5);
    free_req(8);
    free_req(16);
    write_heap_size(13'd0);
    alloc_req(1);
    free_req(8);
    write_heap_size(13'h1FFF);
    alloc_req(4084);
    free_req(8);
    write_heap_size(13'd1003);
    repeat (20) alloc_req($urandom_range(1, 64));
    alloc_req(900);
    write_heap_size(13'd4096);
  endtask

  task automatic random_mix(int count);
    int k;
    int unsigned off;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        alloc_req(($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, 48));
      end else if (k < 88 && live_blocks.size() != 0) begin
        free_req(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      end else if (k < 94) begin
        free_req($urandom_range(0, 4095));
      end else begin
        off = $urandom_range(1, 511) * 8;
        free_req(off);
      end
    end
  endtask

  task automatic test_random();
    send_idle = 1'b1;
    rx_stall_on = 1'b1;
    random_mix(250);
    send_idle = 1'b0;
    rx_stall_on = 1'b0;
    random_mix(100);
    send_idle = 1'b1;
    rx_stall_on = 1'b1;
    write_heap_size(13'($urandom_range(16, 600)));
    random_mix(100);
    write_heap_size(13'd4096);
    random_mix(100);
  endtask

  task automatic test_backpressure();
    wait_drain();
    hold_req = 1'b1;
    send_idle = 1'b0;
    random_mix(30);
    send_idle = 1'b1;
    wait_drain();
    random_mix(20);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_word = '0;
    rsp_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    heap_resize(13'd4096);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_heap_sizes();
    test_random();
    test_backpressure();
    wait_drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
